FILE: design/fpss_pkg.sv
`default_nettype none

package fpss_pkg;

  localparam int unsigned PosW   = 6;
  localparam int unsigned CountW = 12;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 2;

  // reported phase codes
  localparam logic [PhaseW-1:0] PH_IDLE    = 3'd0;
  localparam logic [PhaseW-1:0] PH_SENSE   = 3'd1;
  localparam logic [PhaseW-1:0] PH_COMPARE = 3'd2;
  localparam logic [PhaseW-1:0] PH_START   = 3'd3;
  localparam logic [PhaseW-1:0] PH_WAIT    = 3'd4;
  localparam logic [PhaseW-1:0] PH_STOP    = 3'd5;
  localparam logic [PhaseW-1:0] PH_TOGGLE  = 3'd6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_TARGET    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_START_LOW = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RELEASE   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TOGGLE    = 2'd3;

  localparam logic [PosW-1:0]   TARGET_RST    = 6'd0;
  localparam logic [CountW-1:0] START_LOW_RST = 12'd100;
  localparam logic [CountW-1:0] RELEASE_RST   = 12'd30;
  localparam logic [CountW-1:0] TOGGLE_RST    = 12'd125;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SENSE   = 7'b0000010,
    ST_COMPARE = 7'b0000100,
    ST_START   = 7'b0001000,
    ST_WAIT    = 7'b0010000,
    ST_STOP    = 7'b0100000,
    ST_TOGGLE  = 7'b1000000
  } state_t;

  function automatic logic [PhaseW-1:0] phase_code(input state_t st);
    logic [PhaseW-1:0] code;
    unique case (st)
      ST_IDLE:    code = PH_IDLE;
      ST_SENSE:   code = PH_SENSE;
      ST_COMPARE: code = PH_COMPARE;
      ST_START:   code = PH_START;
      ST_WAIT:    code = PH_WAIT;
      ST_STOP:    code = PH_STOP;
      ST_TOGGLE:  code = PH_TOGGLE;
      default:    code = PH_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: design/fpss_in_if.sv
`default_nettype none

interface fpss_in_if;
  logic                         valid;
  logic                         ready;
  logic [fpss_pkg::PosW-1:0]    port_sample;

  modport source (output valid, output port_sample, input ready);
  modport sink   (input valid, input port_sample, output ready);
endinterface

`default_nettype wire

FILE: design/fpss_out_if.sv
`default_nettype none

interface fpss_out_if;
  logic                         valid;
  logic                         ready;
  logic                         adc_line;
  logic                         col_line;
  logic                         start_line;
  logic [fpss_pkg::PosW-1:0]    measured_position;
  logic [fpss_pkg::PhaseW-1:0]  phase;

  modport source (output valid, output adc_line, output col_line, output start_line,
                  output measured_position, output phase, input ready);
  modport sink   (input valid, input adc_line, input col_line, input start_line,
                  input measured_position, input phase, output ready);
endinterface

`default_nettype wire

FILE: design/flap_position_step_sequencer_top.sv
// The result is registered and is valid in the cycle after the input transfer.
// Throughput: one item per cycle; a new item is taken whenever the result
// register is empty or is being drained in the same cycle.
// Reset (rst_n low, synchronous): sequencer idle, count zero, all pins
// released, position zero, registers at their defaults, no result pending.
`default_nettype none

module flap_position_step_sequencer_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  fpss_in_if.sink                              in_ch,
  fpss_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [fpss_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [fpss_pkg::CountW-1:0]     cfg_wdata
);

  fpss_pkg::state_t                  state_r, state_nxt;
  logic [fpss_pkg::CountW-1:0]       cnt_r, cnt_nxt;
  logic                              adc_r, adc_nxt;
  logic                              col_r, col_nxt;
  logic                              start_r, start_nxt;
  logic [fpss_pkg::PosW-1:0]         pos_r, pos_nxt;
  logic [fpss_pkg::PhaseW-1:0]       phase_r;
  logic                              out_valid_r;

  logic [fpss_pkg::PosW-1:0]         target_r;
  logic [fpss_pkg::CountW-1:0]       start_low_r;
  logic [fpss_pkg::CountW-1:0]       release_r;
  logic [fpss_pkg::CountW-1:0]       toggle_r;

  logic                              in_xfer;
  logic [fpss_pkg::CountW-1:0]       cnt_dec;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign cnt_dec     = cnt_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    adc_nxt   = adc_r;
    col_nxt   = col_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      fpss_pkg::ST_IDLE: begin
        state_nxt = fpss_pkg::ST_SENSE;
        cnt_nxt   = '0;
      end
      fpss_pkg::ST_SENSE: begin
        adc_nxt = 1'b0;
        col_nxt = 1'b0;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_dec;
        end else begin
          state_nxt = fpss_pkg::ST_COMPARE;
        end
      end
      fpss_pkg::ST_COMPARE: begin
        pos_nxt   = in_ch.port_sample - 1'b1;
        state_nxt = (pos_nxt != target_r) ? fpss_pkg::ST_START : fpss_pkg::ST_IDLE;
        adc_nxt   = 1'b1;
        col_nxt   = 1'b1;
      end
      fpss_pkg::ST_START: begin
        adc_nxt   = 1'b0;
        col_nxt   = 1'b0;
        start_nxt = 1'b0;
        cnt_nxt   = start_low_r;
        state_nxt = fpss_pkg::ST_WAIT;
      end
      fpss_pkg::ST_WAIT: begin
        if (cnt_r == '0) begin
          adc_nxt   = 1'b1;
          col_nxt   = 1'b1;
          cnt_nxt   = release_r;
          state_nxt = fpss_pkg::ST_STOP;
        end else begin
          cnt_nxt = cnt_dec;
        end
      end
      fpss_pkg::ST_STOP: begin
        if (cnt_r == '0) begin
          start_nxt = 1'b1;
          cnt_nxt   = toggle_r;
          state_nxt = fpss_pkg::ST_TOGGLE;
        end else begin
          cnt_nxt = cnt_dec;
        end
      end
      fpss_pkg::ST_TOGGLE: begin
        if (cnt_r != '0) begin
          // lower ADC on even counts, release on odd
          adc_nxt = cnt_r[0];
          cnt_nxt = cnt_dec;
        end else begin
          state_nxt = fpss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fpss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpss_pkg::ST_IDLE;
      cnt_r       <= '0;
      adc_r       <= 1'b1;
      col_r       <= 1'b1;
      start_r     <= 1'b1;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r <= state_nxt;
        cnt_r   <= cnt_nxt;
        adc_r   <= adc_nxt;
        col_r   <= col_nxt;
        start_r <= start_nxt;
        pos_r   <= pos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pins and position are held in the state registers; only the phase
  // executed needs its own result register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      phase_r <= fpss_pkg::phase_code(state_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= fpss_pkg::TARGET_RST;
      start_low_r <= fpss_pkg::START_LOW_RST;
      release_r   <= fpss_pkg::RELEASE_RST;
      toggle_r    <= fpss_pkg::TOGGLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpss_pkg::REG_TARGET:    target_r    <= cfg_wdata[fpss_pkg::PosW-1:0];
        fpss_pkg::REG_START_LOW: start_low_r <= cfg_wdata;
        fpss_pkg::REG_RELEASE:   release_r   <= cfg_wdata;
        fpss_pkg::REG_TOGGLE:    toggle_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.adc_line          = adc_r;
  assign out_ch.col_line          = col_r;
  assign out_ch.start_line        = start_r;
  assign out_ch.measured_position = pos_r;
  assign out_ch.phase             = phase_r;

endmodule

`default_nettype wire
